// ===== rtl/core/deque_with_value_removal_macros.svh =====
// ----------------------------------------------------------------------------
// deque_with_value_removal_macros
// Assertion macros used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_VALUE_REMOVAL_MACROS_SVH
`define DEQUE_WITH_VALUE_REMOVAL_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DQVR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DQVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dqvr_pkg.sv =====
// ----------------------------------------------------------------------------
// dqvr_pkg
// Shared constants and types for the deque with removal by value.
// ----------------------------------------------------------------------------
package dqvr_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;
  localparam int CNTX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 72;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic              en;
    op_t               op;
    logic [VAL_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/deque_with_value_removal.sv =====
// The result of each transaction passes a pending stage, then the output
// register, before it is offered on the output.
// Throughput: one transaction per cycle while the output side keeps up; the
// row of cells compares and shifts every slot in the cycle of acceptance.
// Reset (rst, synchronous, active high) empties the store and discards any
// result not yet delivered; slot contents are not cleared.
// ----------------------------------------------------------------------------
// deque_with_value_removal
// Bounded ordered store with push at either end, removal of the first equal
// value and clear, built as a row of cells with a registered result stage.
// ----------------------------------------------------------------------------
`include "deque_with_value_removal_macros.svh"

module deque_with_value_removal (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] op, [33:2] value, [39:34] zero
  input  logic [dqvr_pkg::IN_W-1:0]      s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] found, [1] dropped, [6:2] count, [38:7] front_value,
  // [70:39] back_value, [71] zero
  output logic [dqvr_pkg::OUT_W-1:0]     m_tdata
);

  localparam int D = dqvr_pkg::DEPTH;
  localparam int W = dqvr_pkg::VAL_W;

  dqvr_pkg::op_t         in_op;
  logic [W-1:0]          in_value;
  logic                  accept;
  logic                  full;
  logic                  found_now;
  dqvr_pkg::cell_ctrl_t  ctrl;

  logic [W-1:0]          cell_value [D];
  logic [D-1:0]          cell_valid;
  logic [D:0]            seen;

  logic [dqvr_pkg::CNT_W-1:0] occupancy;
  logic [dqvr_pkg::CNT_W-1:0] occupancy_next;

  logic                  pend_valid;
  logic                  pend_found;
  logic                  pend_dropped;
  logic                  advance;

  logic                  out_found;
  logic                  out_dropped;
  logic [dqvr_pkg::COUNT_W-1:0] out_count;
  logic [W-1:0]          out_front;
  logic [W-1:0]          out_back;
  logic [W-1:0]          front_now;
  logic [W-1:0]          back_now;
  logic [dqvr_pkg::CNTX_W-1:0] occ_ext;

  assign in_op    = dqvr_pkg::op_t'(s_tdata[1:0]);
  assign in_value = s_tdata[W+1:2];

  // A pending result is read from the cells, so they stay still until it moves on.
  assign advance  = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || advance;
  assign accept   = s_tvalid && s_tready;

  assign full      = cell_valid[D-1];
  assign found_now = seen[D];

  always_comb begin
    ctrl.op    = in_op;
    ctrl.value = in_value;
    ctrl.en    = accept &&
                 !(full && ((in_op == dqvr_pkg::OP_PUSH_BACK) ||
                            (in_op == dqvr_pkg::OP_PUSH_FRONT)));
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [W-1:0] lv;
    logic         lvd;
    logic [W-1:0] rv;
    logic         rvd;

    if (i == 0) begin : g_first
      assign lv  = in_value;
      assign lvd = 1'b1;
    end else begin : g_mid_l
      assign lv  = cell_value[i-1];
      assign lvd = cell_valid[i-1];
    end

    if (i == D - 1) begin : g_last
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_mid_r
      assign rv  = cell_value[i+1];
      assign rvd = cell_valid[i+1];
    end

    dqvr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_value  (lv),
      .left_valid  (lvd),
      .right_value (rv),
      .right_valid (rvd),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  always_comb begin
    occupancy_next = occupancy;
    if (ctrl.en) begin
      case (in_op)
        dqvr_pkg::OP_PUSH_BACK,
        dqvr_pkg::OP_PUSH_FRONT: occupancy_next = occupancy + 1'b1;
        dqvr_pkg::OP_REMOVE: begin
          if (found_now) begin
            occupancy_next = occupancy - 1'b1;
          end
        end
        dqvr_pkg::OP_CLEAR:      occupancy_next = '0;
        default:                 occupancy_next = occupancy;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // The back slot is the last valid one, found where valid meets invalid.
  always_comb begin
    front_now = cell_valid[0] ? cell_value[0] : '0;
    back_now  = '0;
    for (int i = 0; i < D; i++) begin
      if (cell_valid[i] && ((i == D - 1) || !cell_valid[(i + 1) % D])) begin
        back_now = back_now | cell_value[i];
      end
    end
  end

  assign occ_ext = dqvr_pkg::CNTX_W'(occupancy);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_found   <= (in_op == dqvr_pkg::OP_REMOVE) && found_now;
      pend_dropped <= full && ((in_op == dqvr_pkg::OP_PUSH_BACK) ||
                               (in_op == dqvr_pkg::OP_PUSH_FRONT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found   <= pend_found;
      out_dropped <= pend_dropped;
      out_count   <= occ_ext[dqvr_pkg::COUNT_W-1:0];
      out_front   <= front_now;
      out_back    <= back_now;
    end
  end

  assign m_tdata = {1'b0, out_back, out_front, out_count, out_dropped, out_found};

  `DQVR_ASSERT_NOW(a_valid_count, 1'b1, $countones(cell_valid) == occupancy, "valid slots disagree with occupancy")
  `DQVR_ASSERT_NOW(a_valid_packed, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0, "valid slots not packed at the front")
  `DQVR_ASSERT_NEXT(a_clear_empties, accept && (in_op == dqvr_pkg::OP_CLEAR), occupancy == '0, "clear left entries behind")
  `DQVR_ASSERT_NOW(a_flags_exclusive, pend_valid, !(pend_found && pend_dropped), "found and dropped both set")
  `DQVR_ASSERT_NOW(a_drop_when_full, pend_valid && pend_dropped, full, "push dropped while space remained")

endmodule

// ===== rtl/core/dqvr_cell.sv =====
// ----------------------------------------------------------------------------
// dqvr_cell
// One storage slot of the deque: holds a value and its valid flag, and takes
// data from either neighbour when the row shifts.
// ----------------------------------------------------------------------------
module dqvr_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  dqvr_pkg::cell_ctrl_t           ctrl,
  input  logic [dqvr_pkg::VAL_W-1:0]     left_value,
  input  logic                           left_valid,
  input  logic [dqvr_pkg::VAL_W-1:0]     right_value,
  input  logic                           right_valid,
  input  logic                           seen_in,
  output logic                           seen_out,
  output logic [dqvr_pkg::VAL_W-1:0]     value,
  output logic                           valid
);

  logic match;

  assign match    = valid && (value == ctrl.value);
  // Marks this slot and every slot behind the first match.
  assign seen_out = seen_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.en) begin
      case (ctrl.op)
        dqvr_pkg::OP_PUSH_BACK: begin
          if (!valid && left_valid) begin
            value <= ctrl.value;
            valid <= 1'b1;
          end
        end
        dqvr_pkg::OP_PUSH_FRONT: begin
          value <= left_value;
          valid <= left_valid;
        end
        dqvr_pkg::OP_REMOVE: begin
          if (seen_out) begin
            value <= right_value;
            valid <= right_valid;
          end
        end
        dqvr_pkg::OP_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

endmodule
